[rtl/dvo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dvo_pkg;

	localparam int VERTEX_W = 4;
	localparam int ROW_W    = 16;
	localparam int ROWS     = 16;
	localparam int DEPTH_W  = 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_POP
	} state_t;

	typedef struct packed {
		logic                found;
		logic [VERTEX_W-1:0] idx;
	} pick_t;

endpackage

`default_nettype wire

[rtl/dvo_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dvo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/dvo_pick.sv]
`timescale 1ns / 1ps
`default_nettype none

module dvo_pick (
	input  wire logic [dvo_pkg::ROW_W-1:0] open_bits,
	output dvo_pkg::pick_t                 pick
);

	// lowest set bit wins
	always_comb begin
		pick.found = |open_bits;
		pick.idx   = '0;
		for (int i = dvo_pkg::ROW_W - 1; i >= 0; i--) begin
			if (open_bits[i]) begin
				pick.idx = dvo_pkg::VERTEX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/dfs_visit_order.sv]
`timescale 1ns / 1ps
`default_nettype none
// Depth-first visit order over a graph held as an adjacency matrix.
// Input stream: one adjacency row per transfer; tdata carries row_index in
// bits 3:0 and row_bits in bits 19:4, tlast marks the final row. Rows load
// one per cycle while idle. A transfer with tlast stores its row, then runs
// the walk from the vertex held in the start register (cfg_we / cfg_wdata).
// Output stream: one transfer per visited vertex in visit order, vertex in
// tdata bits 3:0, tlast on the final vertex. A start vertex not below the
// vertex count gives no output.
// The walk steps through one shared lowest-set-bit picker: each advance goes
// through a row read and a pick, and each backtrack through a stack read and
// a pick. The input side is not ready while a walk runs. One output register
// holds a vertex until taken; a stalled receiver holds the walk at its next
// new vertex.
// Reset clears the start register, the visited map, the stack depth and the
// output valid; matrix rows must be written before they are used.
module dfs_visit_order #(
	parameter int VERTICES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // row_index, row_bits
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [7:0]  m_axis_tdata,  // vertex
	output logic             m_axis_tlast
);

	localparam int LIMIT = (VERTICES < dvo_pkg::ROWS) ? VERTICES : dvo_pkg::ROWS;
	localparam logic [dvo_pkg::DEPTH_W-1:0] LIM = dvo_pkg::DEPTH_W'(LIMIT);
	localparam logic [dvo_pkg::ROW_W-1:0] ROW_MASK = (LIMIT >= dvo_pkg::ROW_W) ?
		'1 : dvo_pkg::ROW_W'((1 << LIMIT) - 1);

	localparam int VW = dvo_pkg::VERTEX_W;
	localparam int RW = dvo_pkg::ROW_W;

	dvo_pkg::state_t state_q, state_d;

	logic [VW-1:0]               start_q;
	logic [RW-1:0]               visited_q;
	logic [dvo_pkg::DEPTH_W-1:0] depth_q;
	logic [VW-1:0]               cur_q;
	logic [VW-1:0]               pend_q;
	logic                        out_valid_q;
	logic [VW-1:0]               out_vertex_q;
	logic                        out_last_q;

	logic [VW-1:0] in_row;
	logic [RW-1:0] in_bits;
	logic          in_xfer;
	logic          row_ok;
	logic          start_ok;
	logic          walk_go;
	logic          out_free;

	logic          adj_we;
	logic          adj_re;
	logic [VW-1:0] adj_raddr;
	logic [RW-1:0] adj_rdata;
	logic          stk_we;
	logic          stk_re;
	logic [VW-1:0] stk_raddr;
	logic [VW-1:0] stk_rdata;

	logic [RW-1:0]  open_bits;
	dvo_pkg::pick_t pick;
	logic           do_adv;
	logic           do_pop;
	logic           do_end;

	assign in_row   = s_axis_tdata[3:0];
	assign in_bits  = s_axis_tdata[19:4];
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign row_ok   = {1'b0, in_row} < LIM;
	assign start_ok = {1'b0, start_q} < LIM;
	assign walk_go  = in_xfer && s_axis_tlast && start_ok;
	assign out_free = !out_valid_q || m_axis_tready;

	assign open_bits = adj_rdata & ~visited_q & ROW_MASK;

	dvo_pick u_pick (
		.open_bits (open_bits),
		.pick      (pick)
	);

	dvo_ram #(.WIDTH(RW), .DEPTH(dvo_pkg::ROWS)) u_adj (
		.clk   (clk),
		.we    (adj_we),
		.waddr (in_row),
		.wdata (in_bits & ROW_MASK),
		.re    (adj_re),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	dvo_ram #(.WIDTH(VW), .DEPTH(dvo_pkg::ROWS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[VW-1:0]),
		.wdata (cur_q),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		adj_we        = 1'b0;
		adj_re        = 1'b0;
		adj_raddr     = cur_q;
		do_adv        = 1'b0;
		do_pop        = 1'b0;
		do_end        = 1'b0;
		case (state_q)
			dvo_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				adj_we        = in_xfer && row_ok;
			end
			dvo_pkg::ST_READ: begin
				adj_re = 1'b1;
			end
			dvo_pkg::ST_EVAL: begin
				do_adv = pick.found && out_free;
				do_pop = !pick.found && (depth_q != '0);
				do_end = !pick.found && (depth_q == '0) && out_free;
			end
			dvo_pkg::ST_POP: begin
				adj_re    = 1'b1;
				adj_raddr = stk_rdata;
			end
			default: begin
			end
		endcase
	end

	assign stk_we    = do_adv;
	assign stk_re    = do_pop;
	assign stk_raddr = VW'(depth_q - dvo_pkg::DEPTH_W'(1));

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dvo_pkg::ST_IDLE: begin
				if (walk_go) begin
					state_d = dvo_pkg::ST_READ;
				end
			end
			dvo_pkg::ST_READ: begin
				state_d = dvo_pkg::ST_EVAL;
			end
			dvo_pkg::ST_EVAL: begin
				if (do_adv) begin
					state_d = dvo_pkg::ST_READ;
				end else if (do_pop) begin
					state_d = dvo_pkg::ST_POP;
				end else if (do_end) begin
					state_d = dvo_pkg::ST_IDLE;
				end
			end
			dvo_pkg::ST_POP: begin
				state_d = dvo_pkg::ST_EVAL;
			end
			default: begin
				state_d = dvo_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dvo_pkg::ST_IDLE;
			start_q     <= '0;
			visited_q   <= '0;
			depth_q     <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
			if (in_xfer && s_axis_tlast) begin
				depth_q   <= '0;
				visited_q <= start_ok ? (RW'(1) << start_q) : '0;
				cur_q     <= start_q;
			end else if (do_adv) begin
				depth_q   <= depth_q + dvo_pkg::DEPTH_W'(1);
				visited_q <= visited_q | (RW'(1) << pick.idx);
				cur_q     <= pick.idx;
			end else if (do_pop) begin
				depth_q <= depth_q - dvo_pkg::DEPTH_W'(1);
			end else if (state_q == dvo_pkg::ST_POP) begin
				cur_q <= stk_rdata;
			end
			if (do_adv || do_end) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// vertex found but not yet sent, held until its last flag is known
	always_ff @(posedge clk) begin
		if (walk_go) begin
			pend_q <= start_q;
		end else if (do_adv) begin
			pend_q <= pick.idx;
		end
		if (do_adv || do_end) begin
			out_vertex_q <= pend_q;
			out_last_q   <= do_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_vertex_q};
	assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q < LIM)
		else $error("stack depth beyond vertex count");

	a_cur_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dvo_pkg::ST_EVAL) |-> visited_q[cur_q])
		else $error("current vertex not marked visited");

	a_adv_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		do_adv |-> !visited_q[pick.idx])
		else $error("advance to a visited vertex");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		do_end |=> (m_axis_tvalid && m_axis_tlast))
		else $error("walk end without final transfer");
`endif

endmodule

`default_nettype wire

[tb/dfs_visit_order_check.sv]
`timescale 1ns / 1ps

module dfs_visit_order_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // row_index, row_bits
	input  wire logic        s_axis_tlast,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [7:0]  m_axis_tdata,  // vertex
	input  wire logic        m_axis_tlast,
	output int               failures,
	output int               pending,
	output int               visits
);

	localparam int VW = dvo_pkg::VERTEX_W;
	localparam int RW = dvo_pkg::ROW_W;
	localparam int RN = dvo_pkg::ROWS;

	typedef struct packed {
		logic [VW-1:0] vertex;
		logic          last;
	} visit_t;

	logic [RW-1:0] rows [RN];
	logic [VW-1:0] start_reg;
	visit_t        due_visits [$];
	int            errors = 0;
	int            checked = 0;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t ns: mismatch: %s", $realtime, msg);
	endtask

	// depth-first order from origin over the stored rows, appended to due_visits
	function automatic void walk_order(input logic [VW-1:0] origin);
		logic [RW-1:0] seen;
		logic [RW-1:0] open;
		logic [VW-1:0] trail [RN];
		logic [VW-1:0] here;
		int            depth;
		int            j;
		visit_t        v;
		seen = '0;
		seen[origin] = 1'b1;
		here = origin;
		depth = 0;
		v.vertex = origin;
		v.last = 1'b0;
		due_visits.push_back(v);
		while (1) begin
			open = rows[here] & ~seen;
			if (open != '0) begin
				j = 0;
				while (!open[j])
					j++;
				if (depth < RN) begin
					trail[depth] = here;
					depth++;
				end
				here = j[VW-1:0];
				seen[j] = 1'b1;
				v.vertex = here;
				due_visits.push_back(v);
			end else if (depth > 0) begin
				depth--;
				here = trail[depth];
			end else begin
				break;
			end
		end
		v = due_visits.pop_back();
		v.last = 1'b1;
		due_visits.push_back(v);
	endfunction

	always @(posedge clk) begin : watch
		visit_t want;
		if (!arst_n) begin
			start_reg = '0;
		end else begin
			if (cfg_we)
				start_reg = cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_visits.size() == 0) begin
					report_mismatch($sformatf("unexpected vertex %0d",
						m_axis_tdata[VW-1:0]));
				end else begin
					want = due_visits.pop_front();
					checked++;
					if (m_axis_tdata[VW-1:0] !== want.vertex)
						report_mismatch($sformatf("vertex %0d, wanted %0d",
							m_axis_tdata[VW-1:0], want.vertex));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("tlast %b on vertex %0d, wanted %b",
							m_axis_tlast, want.vertex, want.last));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				rows[s_axis_tdata[VW-1:0]] = s_axis_tdata[VW +: RW];
				if (s_axis_tlast)
					walk_order(start_reg);
			end
		end
		failures <= errors;
		pending <= due_visits.size();
		visits <= checked;
	end

endmodule

[tb/dfs_visit_order_test.sv]
`timescale 1ns / 1ps

module dfs_visit_order_test;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASE_ROWS    = 38;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [7:0]  m_axis_tdata;
	wire         m_axis_tlast;

	int failures;
	int pending;
	int visits;
	int cycles = 0;
	int rows_sent = 0;
	int walks_sent = 0;
	int settings_used = 0;
	bit src_gaps = 1'b1;
	bit sink_gaps = 1'b1;
	bit hold_req = 1'b0;

	dfs_visit_order #(
		.VERTICES(16)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	dfs_visit_order_check order_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.failures     (failures),
		.pending      (pending),
		.visits       (visits)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d visits outstanding", cycles, pending);
			$display("[dfs_visit_order] ERROR");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin : sink
		int gap;
		int hold_left;
		bit held;
		gap = 0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				m_axis_tready <= 1'b0;
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_row(input logic [3:0] idx, input logic [15:0] bits, input logic fin);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, bits, idx};
		s_axis_tlast <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		rows_sent++;
		if (fin)
			walks_sent++;
	endtask

	task automatic set_start(input logic [3:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic finish_phase();
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] random_row();
		logic [15:0] bits;
		case ($urandom_range(0, 4))
			0: bits = 16'($urandom);
			1: bits = 16'($urandom) & 16'($urandom) & 16'($urandom);
			2: bits = 16'hFFFF;
			3: bits = 16'h0000;
			default: bits = 16'(1) << $urandom_range(0, 15);
		endcase
		return bits;
	endfunction

	initial begin : stimulus
		logic [15:0] bits;
		logic [15:0] graph [16];
		int order [16];
		int i;
		int j;
		int k;
		int n;
		int p;
		int pick;
		int tmp;
		int pct;
		int budget;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// path graph over all vertices: every row written, deepest stack
		set_start(4'd0);
		for (i = 0; i < 16; i++) begin
			bits = '0;
			if (i > 0)
				bits[i - 1] = 1'b1;
			if (i < 15)
				bits[i + 1] = 1'b1;
			send_row(i[3:0], bits, i == 15);
		end
		// isolated start, full row with self loop, one-way edges, re-walks
		send_row(4'd0, 16'h0000, 1'b1);
		send_row(4'd0, 16'hFFFF, 1'b1);
		send_row(4'd5, 16'h0001, 1'b0);
		send_row(4'd0, 16'h0020, 1'b1);
		send_row(4'd0, 16'h8001, 1'b1);
		finish_phase();

		set_start(4'd15);
		send_row(4'd15, 16'h0000, 1'b1);
		send_row(4'd15, 16'hFFFF, 1'b1);
		send_row(4'd3, 16'hFFFF, 1'b0);
		send_row(4'd7, 16'h0000, 1'b1);
		finish_phase();

		for (p = 0; p < 6; p++) begin
			src_gaps = (p != 2) && (p != 5);
			sink_gaps = (p != 5);
			if (p == 2)
				hold_req = 1'b1;
			set_start(4'($urandom_range(0, 15)));
			budget = rows_sent + PHASE_ROWS;
			while (rows_sent < budget) begin
				k = $urandom_range(0, 9);
				if (k < 3) begin
					// whole undirected graph, rows in shuffled order
					case ($urandom_range(0, 3))
						0: pct = 6;
						1: pct = 15;
						2: pct = 30;
						default: pct = 70;
					endcase
					for (i = 0; i < 16; i++)
						graph[i] = '0;
					for (i = 0; i < 16; i++)
						for (j = i + 1; j < 16; j++)
							if ($urandom_range(0, 99) < pct) begin
								graph[i][j] = 1'b1;
								graph[j][i] = 1'b1;
							end
					for (i = 0; i < 16; i++)
						order[i] = i;
					for (i = 15; i > 0; i--) begin
						pick = $urandom_range(0, i);
						tmp = order[i];
						order[i] = order[pick];
						order[pick] = tmp;
					end
					for (i = 0; i < 16; i++)
						send_row(order[i][3:0], graph[order[i]], i == 15);
				end else if (k < 8) begin
					n = $urandom_range(1, 4);
					for (i = 0; i < n; i++)
						send_row(4'($urandom_range(0, 15)), random_row(), i == n - 1);
				end else begin
					send_row(4'($urandom_range(0, 15)), random_row(), 1'b1);
				end
			end
			finish_phase();
		end

		$display("covered %0d row transfers and %0d walks under %0d start settings",
			rows_sent, walks_sent, settings_used);
		$display("checked %0d visited vertices, %0d mismatches", visits, failures);
		if (failures == 0 && pending == 0) begin
			$display("[dfs_visit_order] OK");
		end else begin
			$display("[dfs_visit_order] ERROR");
		end
		$finish;
	end

endmodule
